// ===== sv/ffm_pkg.sv =====
`timescale 1ns / 1ps

package ffm_pkg;

  // field widths of the channel words
  localparam int ActW    = 2;
  localparam int ReqW    = 8;
  localparam int StatW   = 3;
  localparam int ThreadW = 8;
  // widest thread id the core supports
  localparam int MaxIdW  = 16;

  typedef logic [ActW-1:0]  action_t;
  typedef logic [StatW-1:0] status_t;

  localparam action_t ActInit   = 2'd0;
  localparam action_t ActLock   = 2'd1;
  localparam action_t ActUnlock = 2'd2;

  localparam status_t StOk           = 3'd0;
  localparam status_t StQueued       = 3'd1;
  localparam status_t StNotInit      = 3'd2;
  localparam status_t StAlreadyOwner = 3'd3;
  localparam status_t StNotOwner     = 3'd4;
  localparam status_t StFull         = 3'd5;
  localparam status_t StAlreadyInit  = 3'd6;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlExec,
    CtlFetch,
    CtlOut
  } ctl_state_t;

  typedef struct packed {
    logic load_in;  // capture the input word
    logic exec;     // apply the request to the lock state
    logic fetch;    // load the next owner from the queue memory
  } ffm_cmd_t;

  typedef struct packed {
    logic need_fetch;  // unlock hands the lock to a waiter
  } ffm_sts_t;

endpackage

// ===== sv/ffm_if.sv =====
`timescale 1ns / 1ps

interface ffm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ffm_pkg::ActW-1:0]   action;
  logic [ffm_pkg::ReqW-1:0]   requester;

  modport source (output valid, output action, output requester, input ready);
  modport sink (input valid, input action, input requester, output ready);
endinterface

interface ffm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffm_pkg::StatW-1:0]    status;
  logic                         grant_valid;
  logic [ffm_pkg::ThreadW-1:0]  grant_thread;

  modport source (output valid, output status, output grant_valid, output grant_thread,
                  input ready);
  modport sink (input valid, input status, input grant_valid, input grant_thread,
                output ready);
endinterface

// ===== sv/fifo_fair_mutex_core.sv =====
// FIFO-fair mutex: one request word in, one result word out.
// Result valid in the Out state after Exec, or after Exec and Fetch when an unlock hands the lock to a waiter
// (Fetch is the registered read of the wait-queue memory).
// A new word is taken only in idle, after the previous result word has left; an output stall holds it.
// Reset (rst_n low, synchronous): uninitialized, free, queue empty; queue memory not cleared.
`timescale 1ns / 1ps

module fifo_fair_mutex_core #(
  parameter int QUEUE_DEPTH = 16,  // waiting slots, owner included (2..256)
  parameter int ID_BITS     = 8    // stored thread id width (2..16)
) (
  input  logic       clk,
  input  logic       rst_n,
  ffm_in_if.sink     in_chan,
  ffm_out_if.source  out_chan
);

  ffm_pkg::ffm_cmd_t cmd;
  ffm_pkg::ffm_sts_t sts;

  // Controller: idle -> exec -> (fetch) -> out. One word in flight at a time.
  ffm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: lock flags, queue pointers, wait-queue RAM and result register.
  // The owner always sits at the queue head; an unlock pops it and the new
  // head becomes the owner.
  ffm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_chan.action),
    .in_requester     (in_chan.requester),
    .out_status       (out_chan.status),
    .out_grant_valid  (out_chan.grant_valid),
    .out_grant_thread (out_chan.grant_thread)
  );

endmodule

// ===== sv/ffm_ram.sv =====
`timescale 1ns / 1ps

module ffm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffm_ctrl.sv =====
`timescale 1ns / 1ps

module ffm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ffm_pkg::ffm_sts_t sts,
  output ffm_pkg::ffm_cmd_t cmd
);

  ffm_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffm_pkg::CtlIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ffm_pkg::CtlIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ffm_pkg::CtlExec;
        end
      end
      ffm_pkg::CtlExec: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_fetch ? ffm_pkg::CtlFetch : ffm_pkg::CtlOut;
      end
      ffm_pkg::CtlFetch: begin
        cmd.fetch = 1'b1;
        state_nxt = ffm_pkg::CtlOut;
      end
      ffm_pkg::CtlOut: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ffm_pkg::CtlIdle;
        end
      end
      default: begin
        state_nxt = ffm_pkg::CtlIdle;
      end
    endcase
  end

endmodule

// ===== sv/ffm_dp.sv =====
`timescale 1ns / 1ps

module ffm_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffm_pkg::ffm_cmd_t             cmd,
  output ffm_pkg::ffm_sts_t             sts,
  input  logic [ffm_pkg::ActW-1:0]      in_action,
  input  logic [ffm_pkg::ReqW-1:0]      in_requester,
  output logic [ffm_pkg::StatW-1:0]     out_status,
  output logic                          out_grant_valid,
  output logic [ffm_pkg::ThreadW-1:0]   out_grant_thread
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW = PtrW + 1;

  // captured request (payload)
  ffm_pkg::action_t    act_r;
  logic [ID_BITS-1:0]  req_r;

  // lock state
  logic                init_r, init_nxt;
  logic                held_r, held_nxt;
  logic [ID_BITS-1:0]  holder_r, holder_nxt;
  logic [PtrW-1:0]     head_r, head_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  // result word (payload)
  ffm_pkg::status_t           stat_r, stat_nxt;
  logic                       gvld_r, gvld_nxt;
  logic [ffm_pkg::ThreadW-1:0] gthr_r, gthr_nxt;

  logic [ffm_pkg::MaxIdW-1:0] req_ext, rd_ext;
  logic [ID_BITS-1:0]         req_id, ram_rdata;
  logic [SumW-1:0]            tail_sum, head_inc;
  logic [PtrW-1:0]            tail;
  logic [CntW-1:0]            count_dec;
  logic                       ram_we;

  // ids wider than the requester field are zero-extended, narrower ones masked
  assign req_ext = ffm_pkg::MaxIdW'(in_requester);
  assign req_id  = req_ext[ID_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= ffm_pkg::action_t'(in_action);
      req_r <= req_id;
    end
  end

  // tail = (head + count) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum = SumW'(head_r) + SumW'(count_r);
    if (tail_sum >= SumW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
    end
    tail = tail_sum[PtrW-1:0];
  end

  always_comb begin
    head_inc = SumW'(head_r) + SumW'(1);
    if (head_inc == SumW'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  assign count_dec  = (count_r != '0) ? count_r - CntW'(1) : count_r;

  always_comb begin
    init_nxt       = init_r;
    held_nxt       = held_r;
    holder_nxt     = holder_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    stat_nxt       = ffm_pkg::StOk;
    gvld_nxt       = 1'b0;
    gthr_nxt       = '0;
    ram_we         = 1'b0;
    sts.need_fetch = 1'b0;
    case (act_r)
      ffm_pkg::ActInit: begin
        if (init_r) begin
          stat_nxt = ffm_pkg::StAlreadyInit;
        end else begin
          init_nxt   = 1'b1;
          held_nxt   = 1'b0;
          holder_nxt = '0;
          head_nxt   = '0;
          count_nxt  = '0;
        end
      end
      ffm_pkg::ActLock: begin
        if (!init_r) begin
          stat_nxt = ffm_pkg::StNotInit;
        end else if (held_r && holder_r == req_r) begin
          stat_nxt = ffm_pkg::StAlreadyOwner;
        end else if (count_r == CntW'(QUEUE_DEPTH)) begin
          stat_nxt = ffm_pkg::StFull;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CntW'(1);
          if (!held_r) begin
            held_nxt   = 1'b1;
            holder_nxt = req_r;
            gvld_nxt   = 1'b1;
            gthr_nxt   = ffm_pkg::ThreadW'(ffm_pkg::MaxIdW'(req_r));
          end else begin
            stat_nxt = ffm_pkg::StQueued;
          end
        end
      end
      ffm_pkg::ActUnlock: begin
        if (!init_r) begin
          stat_nxt = ffm_pkg::StNotInit;
        end else if (holder_r != req_r) begin
          stat_nxt = ffm_pkg::StNotOwner;
        end else if (held_r) begin
          if (count_r != '0) begin
            head_nxt  = head_inc[PtrW-1:0];
            count_nxt = count_dec;
          end
          if (count_dec != '0) begin
            // next owner comes out of the memory in the following Fetch state
            gvld_nxt       = 1'b1;
            sts.need_fetch = 1'b1;
          end else begin
            held_nxt   = 1'b0;
            holder_nxt = '0;
          end
        end
      end
      default: begin
        stat_nxt = ffm_pkg::StOk;
      end
    endcase
  end

  ffm_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.exec && ram_we),
    .waddr (tail),
    .wdata (req_r),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign rd_ext = ffm_pkg::MaxIdW'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= 1'b0;
      held_r   <= 1'b0;
      holder_r <= '0;
      head_r   <= '0;
      count_r  <= '0;
    end else if (cmd.exec) begin
      init_r   <= init_nxt;
      held_r   <= held_nxt;
      holder_r <= holder_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
    end else if (cmd.fetch) begin
      holder_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stat_r <= stat_nxt;
      gvld_r <= gvld_nxt;
      gthr_r <= gthr_nxt;
    end else if (cmd.fetch) begin
      gthr_r <= rd_ext[ffm_pkg::ThreadW-1:0];
    end
  end

  assign out_status       = stat_r;
  assign out_grant_valid  = gvld_r;
  assign out_grant_thread = gthr_r;

endmodule
